// ===== src/arp_table_with_aging_and_retry_top_assert.svh =====
// assertion macros for the address table block
`ifndef ARP_TABLE_WITH_AGING_AND_RETRY_TOP_ASSERT_SVH
`define ARP_TABLE_WITH_AGING_AND_RETRY_TOP_ASSERT_SVH
// property that must hold whenever out of reset
`define ARP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// implication checked in the cycle after the antecedent
`define ARP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== src/arpt_pkg.sv =====
package arpt_pkg;
	localparam int TableDepthDefault = 32;
	localparam int PendingDepthDefault = 8;
	localparam int IpW = 32;
	localparam int MacW = 48;
	localparam int IfW = 4;
	localparam int StampW = 16;
	localparam int TriesW = 4;
	localparam int KindW = 3;
	localparam logic [15:0] LfsrSeed = 16'hACE1;
	localparam logic [15:0] LfsrTaps = 16'hB400;
	localparam logic [7:0] TimeoutReset = 8'd15;
	localparam logic [3:0] RetriesReset = 4'd5;

	typedef enum logic [1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_PEND   = 2'd2,
		CMD_TICK   = 2'd3
	} cmd_t;

	typedef enum logic [KindW-1:0] {
		KIND_LOOKUP  = 3'd0,
		KIND_SEND    = 3'd1,
		KIND_RELEASE = 3'd2,
		KIND_DROP    = 3'd3,
		KIND_DONE    = 3'd4,
		KIND_FULL    = 3'd5
	} kind_t;

	localparam logic REG_TIMEOUT = 1'b0;
	localparam logic REG_RETRIES = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ACT,
		ST_PEND,
		ST_EMIT,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic take;       // latch input transaction
		logic scan_clr;   // restart table scan
		logic scan_step;  // examine one table entry
		logic act;        // perform table update for the command
		logic pend_clr;   // restart pending walk
		logic pend_step;  // examine one pending slot
		logic emit_done;  // load closing result
		logic out_load;   // push staged result into output register
	} ctrl_t;

	// datapath to controller
	typedef struct packed {
		cmd_t cmd;
		logic scan_end;
		logic pend_end;
		logic pend_hit;   // current pending slot yields a result
		logic out_busy;   // output register full and not taken
	} stat_t;
endpackage

// ===== src/arpt_stream_if.sv =====
interface arpt_stream_if #(parameter int W = 8);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== src/arpt_ctrl.sv =====
module arpt_ctrl import arpt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t st,
	output ctrl_t ctl
);
	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		ctl = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.take = 1'b1;
					ctl.scan_clr = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				ctl.scan_step = 1'b1;
				if (st.scan_end) state_d = ST_ACT;
			end
			ST_ACT: begin
				ctl.act = 1'b1;
				ctl.pend_clr = 1'b1;
				state_d = (st.cmd == CMD_INSERT || st.cmd == CMD_TICK) ? ST_PEND : ST_EMIT;
			end
			ST_PEND: begin
				if (st.pend_end) state_d = ST_DONE;
				else if (!(st.pend_hit && st.out_busy)) begin
					ctl.pend_step = 1'b1;
					ctl.out_load = st.pend_hit;
				end
			end
			ST_EMIT: begin
				if (!st.out_busy) begin
					ctl.emit_done = 1'b1;
					ctl.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_DONE: begin
				if (!st.out_busy) begin
					ctl.emit_done = 1'b1;
					ctl.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

// ===== src/arpt_dpath.sv =====
module arpt_dpath import arpt_pkg::*; #(
	parameter int TableDepth = TableDepthDefault,
	parameter int PendingDepth = PendingDepthDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic [1:0] command,
	input  logic [IpW-1:0] ip_addr,
	input  logic [MacW-1:0] mac_addr,
	input  logic [IfW-1:0] iface_id,
	input  ctrl_t ctl,
	output stat_t st,
	output logic out_valid,
	input  logic out_ready,
	output logic [KindW-1:0] kind,
	output logic hit,
	output logic [IpW-1:0] out_ip,
	output logic [MacW-1:0] out_mac,
	output logic [IfW-1:0] out_iface,
	output logic last
);
	localparam int TW = $clog2(TableDepth);
	localparam int PW = (PendingDepth > 1) ? $clog2(PendingDepth) : 1;
	localparam int TC = TW + 1;
	localparam int PC = $clog2(PendingDepth + 1);

	// configuration
	logic [7:0] timeout_q;
	logic [3:0] retries_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TimeoutReset;
			retries_q <= RetriesReset;
		end else if (cfg_we) begin
			if (cfg_index == REG_TIMEOUT) timeout_q <= cfg_data;
			else retries_q <= cfg_data[3:0];
		end
	end

	// latched transaction
	cmd_t cmd_q;
	logic [IpW-1:0] ip_q;
	logic [MacW-1:0] mac_q;
	logic [IfW-1:0] if_q;
	always_ff @(posedge clk) begin
		if (ctl.take) begin
			cmd_q <= cmd_t'(command);
			ip_q <= ip_addr;
			mac_q <= mac_addr;
			if_q <= iface_id;
		end
	end

	// entry tables: ip/stamp in flops, mac in a memory
	logic [TableDepth-1:0] ev_q;
	logic [IpW-1:0] eip_q [TableDepth];
	logic [StampW-1:0] estamp_q [TableDepth];
	logic [MacW-1:0] emac_mem [TableDepth];
	logic [MacW-1:0] emac_rd;
	logic [StampW-1:0] now_q;
	logic [15:0] lfsr_q;

	// scan state: one entry per cycle
	logic [TC-1:0] sidx_q;
	logic [TW-1:0] sidx;
	logic found_q, free_q;
	logic [TW-1:0] fidx_q, freeidx_q;
	assign sidx = sidx_q[TW-1:0];
	assign st.scan_end = (sidx_q == TC'(TableDepth - 1));

	logic match_e;
	assign match_e = ev_q[sidx] && (eip_q[sidx] == ip_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sidx_q <= '0;
			found_q <= 1'b0;
			free_q <= 1'b0;
		end else if (ctl.scan_clr) begin
			sidx_q <= '0;
			found_q <= 1'b0;
			free_q <= 1'b0;
		end else if (ctl.scan_step) begin
			if (!st.scan_end) sidx_q <= sidx_q + 1'b1;
			if (match_e && !found_q) found_q <= 1'b1;
			if (!ev_q[sidx] && !free_q) free_q <= 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (ctl.scan_step) begin
			if (match_e && !found_q) fidx_q <= sidx;
			if (!ev_q[sidx] && !free_q) freeidx_q <= sidx;
		end
	end

	// age test for tick, done per entry during scan
	logic [StampW-1:0] age;
	assign age = now_q + 1'b1 - estamp_q[sidx];

	// lfsr next and replacement slot
	logic [15:0] lfsr_nx;
	assign lfsr_nx = (lfsr_q >> 1) ^ (lfsr_q[0] ? LfsrTaps : 16'h0);

	// lfsr_nx mod TableDepth by reciprocal multiply over two stages,
	// settled long before the next insert reaches its update
	localparam logic [31:0] RecipM =
		32'(((64'd1 << 32) + 64'(TableDepth) - 64'd1) / 64'(TableDepth));
	logic [47:0] repl_prod;
	logic [15:0] repl_quo_s1, repl_x_s1;
	logic [15:0] repl_rem;
	logic [TW-1:0] repl_slot_s2;
	assign repl_prod = 48'(lfsr_nx) * 48'(RecipM);
	assign repl_rem = repl_x_s1 - 16'(repl_quo_s1 * 16'(TableDepth));
	always_ff @(posedge clk) begin
		repl_quo_s1 <= repl_prod[47:32];
		repl_x_s1 <= lfsr_nx;
		repl_slot_s2 <= repl_rem[TW-1:0];
	end

	logic [TW-1:0] wslot;
	always_comb begin
		if (found_q) wslot = fidx_q;
		else if (free_q) wslot = freeidx_q;
		else wslot = repl_slot_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_q <= '0;
			now_q <= '0;
			lfsr_q <= LfsrSeed;
		end else begin
			if (ctl.scan_step && cmd_q == CMD_TICK && ev_q[sidx] && age > StampW'(timeout_q))
				ev_q[sidx] <= 1'b0;
			if (ctl.act && cmd_q == CMD_TICK) now_q <= now_q + 1'b1;
			if (ctl.act && cmd_q == CMD_INSERT) begin
				ev_q[wslot] <= 1'b1;
				if (!found_q && !free_q) lfsr_q <= lfsr_nx;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (ctl.act && cmd_q == CMD_INSERT) begin
			eip_q[wslot] <= ip_q;
			estamp_q[wslot] <= now_q;
			emac_mem[wslot] <= mac_q;
		end
		// registered memory read for lookup answer
		if (ctl.act) emac_rd <= emac_mem[fidx_q];
	end

	// pending table
	logic [PendingDepth-1:0] pv_q;
	logic [IpW-1:0] pip_q [PendingDepth];
	logic [IfW-1:0] pif_q [PendingDepth];
	logic [TriesW-1:0] ptr_q [PendingDepth];
	logic [PC-1:0] pidx_q;
	logic [PW-1:0] pidx;
	assign pidx = pidx_q[PW-1:0];
	assign st.pend_end = (pidx_q == PC'(PendingDepth));

	// pend command: search all slots at once (small table)
	logic popen;
	logic pfree_any;
	logic [PW-1:0] pfree;
	always_comb begin
		popen = 1'b0;
		pfree_any = 1'b0;
		pfree = '0;
		for (int i = PendingDepth - 1; i >= 0; i--) begin
			if (pv_q[i]) begin
				if (pip_q[i] == ip_q && pif_q[i] == if_q) popen = 1'b1;
			end else begin
				pfree_any = 1'b1;
				pfree = PW'(i);
			end
		end
	end

	logic pcur_hit, pcur_send;
	always_comb begin
		pcur_send = pv_q[pidx] && (ptr_q[pidx] < retries_q);
		if (st.pend_end) pcur_hit = 1'b0;
		else if (cmd_q == CMD_TICK) pcur_hit = pv_q[pidx];
		else pcur_hit = pv_q[pidx] && (pip_q[pidx] == ip_q);
	end
	assign st.pend_hit = pcur_hit;
	assign st.cmd = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q <= '0;
			pidx_q <= '0;
		end else begin
			if (ctl.pend_clr) pidx_q <= '0;
			else if (ctl.pend_step) pidx_q <= pidx_q + 1'b1;
			if (ctl.pend_step && pcur_hit && !(cmd_q == CMD_TICK && pcur_send))
				pv_q[pidx] <= 1'b0;
			if (ctl.act && cmd_q == CMD_PEND && !popen && pfree_any) pv_q[pfree] <= 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (ctl.pend_step && pcur_hit && cmd_q == CMD_TICK && pcur_send)
			ptr_q[pidx] <= ptr_q[pidx] + 1'b1;
		if (ctl.act && cmd_q == CMD_PEND && !popen && pfree_any) begin
			pip_q[pfree] <= ip_q;
			pif_q[pfree] <= if_q;
			ptr_q[pfree] <= TriesW'(1);
		end
	end

	// single-item result, decided at act
	kind_t one_kind_q;
	logic one_hit_q;
	logic [IfW-1:0] one_if_q;
	always_ff @(posedge clk) begin
		if (ctl.act) begin
			one_hit_q <= found_q;
			one_if_q <= '0;
			case (cmd_q)
				CMD_LOOKUP: one_kind_q <= KIND_LOOKUP;
				CMD_PEND: begin
					one_if_q <= if_q;
					if (popen) one_kind_q <= KIND_DONE;
					else if (pfree_any) one_kind_q <= KIND_SEND;
					else one_kind_q <= KIND_FULL;
				end
				default: one_kind_q <= KIND_DONE;
			endcase
		end
	end

	// staged result
	kind_t s_kind;
	logic s_hit, s_last;
	logic [IpW-1:0] s_ip;
	logic [MacW-1:0] s_mac;
	logic [IfW-1:0] s_if;
	always_comb begin
		s_kind = KIND_DONE;
		s_hit = 1'b0;
		s_ip = ip_q;
		s_mac = '0;
		s_if = '0;
		s_last = 1'b0;
		if (ctl.emit_done) begin
			s_last = 1'b1;
			if (cmd_q == CMD_TICK) s_ip = '0;
			else if (cmd_q == CMD_LOOKUP || cmd_q == CMD_PEND) begin
				s_kind = one_kind_q;
				s_if = one_if_q;
				if (cmd_q == CMD_LOOKUP) begin
					s_hit = one_hit_q;
					s_mac = one_hit_q ? emac_rd : '0;
				end
			end
		end else if (cmd_q == CMD_TICK) begin
			s_kind = pcur_send ? KIND_SEND : KIND_DROP;
			s_ip = pip_q[pidx];
			s_if = pif_q[pidx];
		end else begin
			s_kind = KIND_RELEASE;
			s_mac = mac_q;
			s_if = pif_q[pidx];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (ctl.out_load) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			kind <= s_kind;
			hit <= s_hit;
			out_ip <= s_ip;
			out_mac <= s_mac;
			out_iface <= s_if;
			last <= s_last;
		end
	end
	assign st.out_busy = out_valid && !out_ready;
endmodule

// ===== src/arp_table_with_aging_and_retry_top.sv =====
// ARP cache with aging and request retry. An accepted transaction (lookup, insert,
// pend or tick) first walks the address table one entry per cycle, then performs
// the table update in the act state. Lookup and pend give one result; insert and
// tick then walk the pending table one slot per cycle, pausing while a result waits
// on a held output register, and give up to PendingDepth + 1 results, the last
// flagged. The table scan through the single shared compare sets the rate; the
// block takes the next transaction once the closing result is loaded into the
// output register. Configuration must be written only while idle; the block itself
// does not enforce this.
module arp_table_with_aging_and_retry_top import arpt_pkg::*; #(
	parameter int TableDepth = TableDepthDefault,
	parameter int PendingDepth = PendingDepthDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [7:0] cfg_data,
	arpt_stream_if.sink in_if,
	arpt_stream_if.source out_if
);
	ctrl_t ctl;
	stat_t st;

	arpt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_if.valid), .in_ready(in_if.ready),
		.st(st), .ctl(ctl)
	);

	arpt_dpath #(.TableDepth(TableDepth), .PendingDepth(PendingDepth)) u_dpath (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.command(in_if.data[1:0]),
		.ip_addr(in_if.data[33:2]),
		.mac_addr(in_if.data[81:34]),
		.iface_id(in_if.data[85:82]),
		.ctl(ctl), .st(st),
		.out_valid(out_if.valid), .out_ready(out_if.ready),
		.kind(out_if.data[2:0]),
		.hit(out_if.data[3]),
		.out_ip(out_if.data[35:4]),
		.out_mac(out_if.data[83:36]),
		.out_iface(out_if.data[87:84]),
		.last(out_if.data[88])
	);

	`include "arp_table_with_aging_and_retry_top_assert.svh"

	// no new transaction while a result is still being produced
	`ARP_ASSERT(a_take_idle, !(ctl.take && (ctl.scan_step || ctl.pend_step)), "take while busy")
	// a staged result never overwrites one that is held
	`ARP_ASSERT(a_no_overwrite, !(ctl.out_load && st.out_busy), "output overwritten")
	// after the closing result the block is ready again
	`ARP_ASSERT_NEXT(a_ready_after, ctl.emit_done, in_if.ready, "not ready after last")
endmodule
